/* design/scfb_pkg.sv */
// Shared types and constants for the serial command frame bridge.
// Holds the item codes, reply status codes and the burst descriptor type.
// No dependencies.
`timescale 1ns / 1ps

package scfb_pkg;

    // Received item kinds
    typedef enum logic [1:0] {
        CMD_BYTE      = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_READ_DATA = 2'd2,
        CMD_UNUSED    = 2'd3
    } scfb_cmd_t;

    // Device request opcodes, also the frame command byte values
    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_DCS   = 2'd3
    } scfb_op_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TIMEOUT = 1'd1;

    localparam logic [7:0]  MAX_PAYLOAD_RST  = 8'd255;
    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd500;

    localparam logic [7:0] RX_HEADER = 8'h5A;
    localparam logic [7:0] TX_HEADER = 8'hA5;

    // Reply status codes
    localparam logic [7:0] ST_OK           = 8'h00;
    localparam logic [7:0] ST_TIMEOUT      = 8'h01;
    localparam logic [7:0] ST_BAD_HEADER   = 8'h02;
    localparam logic [7:0] ST_BAD_SIZE     = 8'h03;
    localparam logic [7:0] ST_BAD_CHECKSUM = 8'h04;
    localparam logic [7:0] ST_BAD_COMMAND  = 8'h05;
    localparam logic [7:0] ST_BAD_LENGTH   = 8'h06;

    // Position inside an output burst
    typedef enum logic [2:0] {
        STEP_REQ,
        STEP_HDR,
        STEP_STAT,
        STEP_LEN,
        STEP_D0,
        STEP_D1,
        STEP_SUM
    } scfb_step_t;

    // Everything one item emits: an optional device request, then an
    // optional reply frame with zero or two data bytes.
    typedef struct packed {
        logic        req_en;
        logic [1:0]  dev_op;
        logic [7:0]  dev_reg;
        logic [15:0] dev_value;
        logic        rep_en;
        logic [7:0]  status;
        logic        has_data;
        logic [15:0] data;
    } scfb_burst_t;

endpackage

/* design/scfb_parser.sv */
// Frame parser: holds the frame state and turns one item into a burst descriptor.
// Depends on scfb_pkg.
`timescale 1ns / 1ps

module scfb_parser
    import scfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] read_value,
    input  logic [7:0]  max_payload_len,
    input  logic [15:0] idle_timeout_ticks,
    output scfb_burst_t burst,
    output logic        burst_en
);

    localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

    logic [8:0]  byte_count_reg, byte_count_next;
    logic [7:0]  frame_size_reg, frame_size_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [16:0] idle_ticks_reg, idle_ticks_next;
    logic        read_pending_reg, read_pending_next;
    logic [7:0]  payload_head_reg [4];

    logic [8:0]  bc_inc;
    logic [7:0]  xor_new;
    logic [8:0]  head_pos;
    logic [8:0]  frame_end;
    logic [16:0] idle_inc;
    logic        head_we;
    logic [7:0]  fcmd;
    logic [7:0]  need;
    logic        bad_cmd;

    assign bc_inc    = byte_count_reg + 9'd1;
    assign xor_new   = (byte_count_reg == 9'd0) ? rx_byte : (running_xor_reg ^ rx_byte);
    assign head_pos  = bc_inc - 9'd3;
    assign frame_end = {1'b0, frame_size_reg} + 9'd3;
    assign idle_inc  = (idle_ticks_reg == IDLE_MAX) ? idle_ticks_reg : idle_ticks_reg + 17'd1;
    assign fcmd      = payload_head_reg[0];
    assign bad_cmd   = (frame_size_reg == 8'd0) || (fcmd > {6'd0, OP_DCS});
    assign need      = (fcmd == {6'd0, OP_RESET}) ? 8'd1 :
                       (fcmd == {6'd0, OP_WRITE}) ? 8'd4 : 8'd2;

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        frame_size_next   = frame_size_reg;
        running_xor_next  = running_xor_reg;
        idle_ticks_next   = idle_ticks_reg;
        read_pending_next = read_pending_reg;
        head_we           = 1'b0;
        burst             = '0;
        case (scfb_cmd_t'(command))
            CMD_BYTE:
            begin
                if (!read_pending_reg)
                begin
                    idle_ticks_next  = '0;
                    running_xor_next = xor_new;
                    byte_count_next  = bc_inc;
                    if (bc_inc == 9'd1)
                    begin
                        if (rx_byte != RX_HEADER)
                        begin
                            byte_count_next = '0;
                            burst.rep_en    = 1'b1;
                            burst.status    = ST_BAD_HEADER;
                        end
                    end
                    else if (bc_inc == 9'd2)
                    begin
                        frame_size_next = rx_byte;
                        if (rx_byte > max_payload_len)
                        begin
                            byte_count_next = '0;
                            burst.rep_en    = 1'b1;
                            burst.status    = ST_BAD_SIZE;
                        end
                    end
                    else if (bc_inc < frame_end)
                    begin
                        head_we = (head_pos < 9'd4);
                    end
                    else
                    begin
                        // Checksum byte closes the frame
                        byte_count_next = '0;
                        burst.rep_en    = 1'b1;
                        if (xor_new != 8'd0)
                        begin
                            burst.status = ST_BAD_CHECKSUM;
                        end
                        else if (bad_cmd)
                        begin
                            burst.status = ST_BAD_COMMAND;
                        end
                        else if (frame_size_reg != need)
                        begin
                            burst.status = ST_BAD_LENGTH;
                        end
                        else
                        begin
                            burst.req_en  = 1'b1;
                            burst.dev_op  = fcmd[1:0];
                            burst.dev_reg = (fcmd[1:0] == OP_RESET) ? 8'd0 : payload_head_reg[1];
                            burst.status  = ST_OK;
                            if (fcmd[1:0] == OP_WRITE)
                            begin
                                burst.dev_value = {payload_head_reg[2], payload_head_reg[3]};
                            end
                            if (fcmd[1:0] == OP_READ)
                            begin
                                burst.rep_en      = 1'b0;
                                read_pending_next = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_TICK:
            begin
                if (!read_pending_reg)
                begin
                    idle_ticks_next = idle_inc;
                    if ((byte_count_reg != 9'd0) && (idle_inc > {1'b0, idle_timeout_ticks}))
                    begin
                        byte_count_next = '0;
                        burst.rep_en    = 1'b1;
                        burst.status    = ST_TIMEOUT;
                    end
                end
            end
            CMD_READ_DATA:
            begin
                if (read_pending_reg)
                begin
                    read_pending_next = 1'b0;
                    burst.rep_en      = 1'b1;
                    burst.status      = ST_OK;
                    burst.has_data    = 1'b1;
                    burst.data        = read_value;
                end
            end
            default:
            begin
                // Unused code: no effect
            end
        endcase
    end

    assign burst_en = burst.req_en || burst.rep_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            frame_size_reg   <= '0;
            running_xor_reg  <= '0;
            idle_ticks_reg   <= '0;
            read_pending_reg <= 1'b0;
        end
        else if (take)
        begin
            byte_count_reg   <= byte_count_next;
            frame_size_reg   <= frame_size_next;
            running_xor_reg  <= running_xor_next;
            idle_ticks_reg   <= idle_ticks_next;
            read_pending_reg <= read_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && head_we)
        begin
            payload_head_reg[head_pos[1:0]] <= rx_byte;
        end
    end

endmodule

/* design/scfb_tx.sv */
// Burst serializer: holds one burst descriptor and emits its results one a cycle while out_stall is low.
// Depends on scfb_pkg.
`timescale 1ns / 1ps

module scfb_tx
    import scfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  scfb_burst_t desc,
    output logic        free,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  tx_byte,
    output logic [1:0]  dev_op,
    output logic [7:0]  dev_reg,
    output logic [15:0] dev_value,
    output logic        last
);

    scfb_burst_t burst_reg;
    scfb_step_t  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        accept;
    logic [7:0]  len;
    logic [7:0]  csum;

    assign len  = burst_reg.has_data ? 8'd2 : 8'd0;
    assign csum = TX_HEADER ^ burst_reg.status ^ len ^
                  (burst_reg.has_data ? (burst_reg.data[15:8] ^ burst_reg.data[7:0]) : 8'd0);

    assign out_valid = busy_reg;
    assign accept    = busy_reg && !out_stall;
    assign last      = ((step_reg == STEP_REQ) && !burst_reg.rep_en) || (step_reg == STEP_SUM);
    assign free      = !busy_reg || (accept && last);
    assign kind      = (step_reg == STEP_REQ);
    assign dev_op    = kind ? burst_reg.dev_op : 2'd0;
    assign dev_reg   = kind ? burst_reg.dev_reg : 8'd0;
    assign dev_value = kind ? burst_reg.dev_value : 16'd0;

    always_comb
    begin
        case (step_reg)
            STEP_HDR:  tx_byte = TX_HEADER;
            STEP_STAT: tx_byte = burst_reg.status;
            STEP_LEN:  tx_byte = len;
            STEP_D0:   tx_byte = burst_reg.data[15:8];
            STEP_D1:   tx_byte = burst_reg.data[7:0];
            STEP_SUM:  tx_byte = csum;
            default:   tx_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (load)
        begin
            busy_next = 1'b1;
            step_next = desc.req_en ? STEP_REQ : STEP_HDR;
        end
        else if (accept && last)
        begin
            busy_next = 1'b0;
        end
        else if (accept)
        begin
            case (step_reg)
                STEP_REQ:  step_next = STEP_HDR;
                STEP_HDR:  step_next = STEP_STAT;
                STEP_STAT: step_next = STEP_LEN;
                STEP_LEN:  step_next = burst_reg.has_data ? STEP_D0 : STEP_SUM;
                STEP_D0:   step_next = STEP_D1;
                STEP_D1:   step_next = STEP_SUM;
                default:   step_next = STEP_SUM;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_HDR;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= desc;
        end
    end

endmodule

/* design/serial_command_frame_bridge_core.sv */
// Serial command frame bridge: parses 0x5A framed commands, issues device requests
// and 0xA5 reply frames. An accepted item waits in the input register until the
// serializer is free, then its burst is loaded into the serializer, which drives
// the first result. Throughput: one item per cycle while the output does not stall;
// an item with results holds the serializer until its last result is taken, which
// sets the pace of bursty traffic. Reset (rst_n, async, active low) clears frame
// state, pending read and config to defaults (max size 255, idle timeout 500
// ticks). Depends on scfb_pkg, scfb_parser and scfb_tx.
`timescale 1ns / 1ps

module serial_command_frame_bridge_core
    import scfb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input item channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             command,
    input  logic [7:0]             rx_byte,
    input  logic [15:0]            read_value,
    // Result item channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   kind,
    output logic [7:0]             tx_byte,
    output logic [1:0]             dev_op,
    output logic [7:0]             dev_reg,
    output logic [15:0]            dev_value,
    output logic                   last,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    // Input register
    logic        in_vld_reg;
    logic [1:0]  command_reg;
    logic [7:0]  rx_byte_reg;
    logic [15:0] read_value_reg;

    // Configuration registers
    logic [7:0]  max_payload_len_reg;
    logic [15:0] idle_timeout_ticks_reg;

    scfb_burst_t burst;
    logic        burst_en;
    logic        tx_free;
    logic        advance;

    // Advance the held item into the parser once the serializer can take its burst.
    assign advance   = in_vld_reg && tx_free;
    // Hold the input only while the held item is blocked.
    assign in_stall  = in_vld_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            command_reg    <= command;
            rx_byte_reg    <= rx_byte;
            read_value_reg <= read_value;
        end
    end

    // Write configuration; indexes outside the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_len_reg    <= MAX_PAYLOAD_RST;
            idle_timeout_ticks_reg <= IDLE_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MAX_PAYLOAD)
            begin
                max_payload_len_reg <= cfg_data[7:0];
            end
            if (cfg_index == REG_IDLE_TIMEOUT)
            begin
                idle_timeout_ticks_reg <= cfg_data;
            end
        end
    end

    scfb_parser u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .take               (advance),
        .command            (command_reg),
        .rx_byte            (rx_byte_reg),
        .read_value         (read_value_reg),
        .max_payload_len    (max_payload_len_reg),
        .idle_timeout_ticks (idle_timeout_ticks_reg),
        .burst              (burst),
        .burst_en           (burst_en)
    );

    // Load a burst only for items that emit something; silent items pass through.
    scfb_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && burst_en),
        .desc      (burst),
        .free      (tx_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .dev_op    (dev_op),
        .dev_reg   (dev_reg),
        .dev_value (dev_value),
        .last      (last)
    );

endmodule

/* verif/serial_command_frame_bridge_core_test.sv */
// Self-checking testbench for serial_command_frame_bridge_core: framed command bytes,
// ticks and read data go in, device requests and reply bytes are predicted and checked.
// Depends on scfb_pkg and the bridge RTL only.
`timescale 1ns / 1ps

module serial_command_frame_bridge_core_test;
    import scfb_pkg::*;

    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake at all
    localparam int SQUEEZE_CYCLES = 300; // long output hold-off
    localparam int SETTLE_CYCLES = 10;   // margin for the pipe to empty

    // One input item and one result item as the ports carry them
    typedef struct {
        scfb_cmd_t   code;
        logic [7:0]  data_byte;
        logic [15:0] rd_value;
    } bridge_in_t;

    typedef struct {
        logic        kind;
        logic [7:0]  tx_byte;
        scfb_op_t    dev_op;
        logic [7:0]  dev_reg;
        logic [15:0] dev_value;
        logic        last;
    } bridge_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             command = CMD_TICK;
    logic [7:0]             rx_byte = 8'h00;
    logic [15:0]            read_value = 16'h0000;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   kind;
    logic [7:0]             tx_byte;
    logic [1:0]             dev_op;
    logic [7:0]             dev_reg;
    logic [15:0]            dev_value;
    logic                   last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MAX_PAYLOAD;
    logic [15:0]            cfg_data = 16'h0000;

    serial_command_frame_bridge_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .rx_byte    (rx_byte),
        .read_value (read_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .tx_byte    (tx_byte),
        .dev_op     (dev_op),
        .dev_reg    (dev_reg),
        .dev_value  (dev_value),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Bridge mirror: frame parser state and register copies
    // ------------------------------------------------------------------
    logic [7:0]  lim_len = MAX_PAYLOAD_RST;   // largest accepted size byte
    logic [15:0] tmo_ticks = IDLE_TIMEOUT_RST;
    logic [8:0]  frm_cnt = '0;                // bytes of the frame so far
    logic [7:0]  frm_len = '0;
    logic [7:0]  frm_xor = '0;
    logic [7:0]  head_b [4] = '{default: 8'h00};
    logic [16:0] idle_cnt = '0;
    bit          rd_wait = 1'b0;              // read request awaiting its data

    bridge_out_t step_q [$];   // results of the item being predicted
    bridge_out_t owed_q [$];   // results the block still owes, oldest first
    bridge_in_t  feed_q [$];   // items waiting for the driver
    int          mismatches = 0;
    int          items_in = 0;

    function automatic int cmd_len(logic [7:0] op);
        case (op)
            OP_RESET: return 1;
            OP_WRITE: return 4;
            default:  return 2;
        endcase
    endfunction

    function automatic void add_result(logic k, logic [7:0] tx, scfb_op_t op,
                                       logic [7:0] r, logic [15:0] v);
        bridge_out_t e;
        e.kind = k;
        e.tx_byte = tx;
        e.dev_op = op;
        e.dev_reg = r;
        e.dev_value = v;
        e.last = 1'b0;
        step_q.push_back(e);
    endfunction

    // Reply frame: header, status, length, optional two data bytes, XOR of all before
    function automatic void add_reply(logic [7:0] status, bit with_data, logic [15:0] data);
        logic [7:0] len;
        logic [7:0] chk;
        len = with_data ? 8'd2 : 8'd0;
        chk = TX_HEADER ^ status ^ len;
        add_result(1'b0, TX_HEADER, OP_RESET, 8'h00, 16'h0000);
        add_result(1'b0, status, OP_RESET, 8'h00, 16'h0000);
        add_result(1'b0, len, OP_RESET, 8'h00, 16'h0000);
        if (with_data) begin
            add_result(1'b0, data[15:8], OP_RESET, 8'h00, 16'h0000);
            add_result(1'b0, data[7:0], OP_RESET, 8'h00, 16'h0000);
            chk = chk ^ data[15:8] ^ data[7:0];
        end
        add_result(1'b0, chk, OP_RESET, 8'h00, 16'h0000);
    endfunction

    // Decode a frame whose checksum came out right
    function automatic void close_frame();
        logic [7:0] op;
        op = head_b[0];
        if (frm_len == 8'd0 || op > 8'd3) begin
            add_reply(ST_BAD_COMMAND, 1'b0, 16'h0000);
            return;
        end
        if (int'(frm_len) != cmd_len(op)) begin
            add_reply(ST_BAD_LENGTH, 1'b0, 16'h0000);
            return;
        end
        case (scfb_op_t'(op[1:0]))
            OP_READ: begin
                // reply waits for the read data item
                rd_wait = 1'b1;
                add_result(1'b1, 8'h00, OP_READ, head_b[1], 16'h0000);
                return;
            end
            OP_RESET: add_result(1'b1, 8'h00, OP_RESET, 8'h00, 16'h0000);
            OP_WRITE: add_result(1'b1, 8'h00, OP_WRITE, head_b[1], {head_b[2], head_b[3]});
            default:  add_result(1'b1, 8'h00, OP_DCS, head_b[1], 16'h0000);
        endcase
        add_reply(ST_OK, 1'b0, 16'h0000);
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int pos;
        idle_cnt = '0;
        frm_xor = (frm_cnt == 9'd0) ? b : (frm_xor ^ b);
        frm_cnt = frm_cnt + 9'd1;
        pos = int'(frm_cnt);
        if (pos == 1) begin
            if (b != RX_HEADER) begin
                frm_cnt = '0;
                add_reply(ST_BAD_HEADER, 1'b0, 16'h0000);
            end
        end else if (pos == 2) begin
            frm_len = b;
            if (b > lim_len) begin
                frm_cnt = '0;
                add_reply(ST_BAD_SIZE, 1'b0, 16'h0000);
            end
        end else if (pos < int'(frm_len) + 3) begin
            // keep only the first four payload bytes
            if (pos - 3 < 4)
                head_b[pos - 3] = b;
        end else begin
            // checksum byte: XOR over the whole frame must be zero
            frm_cnt = '0;
            if (frm_xor != 8'h00)
                add_reply(ST_BAD_CHECKSUM, 1'b0, 16'h0000);
            else
                close_frame();
        end
    endfunction

    // Work out every result one accepted item causes and queue them up
    function automatic void predict_item(scfb_cmd_t code, logic [7:0] b, logic [15:0] rv);
        bridge_out_t e;
        step_q.delete();
        case (code)
            CMD_BYTE: begin
                if (!rd_wait)
                    parse_byte(b);
            end
            CMD_TICK: begin
                // ticks freeze while a read is outstanding
                if (!rd_wait) begin
                    if (idle_cnt != 17'h1FFFF)
                        idle_cnt = idle_cnt + 17'd1;
                    if (frm_cnt != 9'd0 && idle_cnt > {1'b0, tmo_ticks}) begin
                        frm_cnt = '0;
                        add_reply(ST_TIMEOUT, 1'b0, 16'h0000);
                    end
                end
            end
            CMD_READ_DATA: begin
                if (rd_wait) begin
                    rd_wait = 1'b0;
                    add_reply(ST_OK, 1'b1, rv);
                end
            end
            default: ;
        endcase
        if (step_q.size() > 0) begin
            e = step_q.pop_back();
            e.last = 1'b1;
            step_q.push_back(e);
        end
        foreach (step_q[i])
            owed_q.push_back(step_q[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers: fill the feed queue, unused fields random
    // ------------------------------------------------------------------
    logic [7:0] body [256];   // payload of the next frame to send

    function automatic void feed(scfb_cmd_t code, logic [7:0] b, logic [15:0] rv);
        bridge_in_t it;
        it.code = code;
        it.data_byte = b;
        it.rd_value = rv;
        feed_q.push_back(it);
    endfunction

    function automatic void feed_byte(logic [7:0] b);
        feed(CMD_BYTE, b, 16'($urandom));
    endfunction

    function automatic void feed_tick();
        feed(CMD_TICK, 8'($urandom), 16'($urandom));
    endfunction

    function automatic void feed_rdata(logic [15:0] v);
        feed(CMD_READ_DATA, 8'($urandom), v);
    endfunction

    // Stray ticks, read data with no read open, and the unused code
    function automatic void feed_noise();
        case ($urandom_range(0, 2))
            0:       feed_tick();
            1:       feed_rdata(16'($urandom));
            default: feed(CMD_UNUSED, 8'($urandom), 16'($urandom));
        endcase
    endfunction

    // Header, size, payload from body[], checksum. A size over the limit
    // stops after the size byte, since the block drops the frame there.
    // A lone tick between bytes never reaches the timeout (limit is at least 1).
    function automatic void send_frame(int size, bit bad_sum);
        logic [7:0] chk;
        chk = RX_HEADER ^ 8'(size);
        feed_byte(RX_HEADER);
        feed_byte(8'(size));
        if (size > int'(lim_len))
            return;
        for (int i = 0; i < size; i++) begin
            if ($urandom_range(0, 7) == 0)
                feed_tick();
            feed_byte(body[i]);
            chk = chk ^ body[i];
        end
        if (bad_sum)
            chk = chk ^ (8'h01 << $urandom_range(0, 7));
        feed_byte(chk);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Well-formed frames with random content, mixed with broken ones and noise
    function automatic void random_traffic(int n);
        int start;
        int pick;
        int size;
        int op;
        logic [7:0] b;
        start = feed_q.size();
        while (feed_q.size() - start < n) begin
            pick = $urandom_range(0, 99);
            op = $urandom_range(0, 3);
            body[0] = 8'(op);
            for (int i = 1; i < 8; i++)
                body[i] = 8'($urandom);
            if (pick < 40) begin
                send_frame(cmd_len(8'(op)), 1'b0);
                if (op == OP_READ) begin
                    // bytes and ticks while the read is open get dropped
                    repeat ($urandom_range(0, 2)) begin
                        if ($urandom_range(0, 1) == 0)
                            feed_byte(8'($urandom));
                        else
                            feed_tick();
                    end
                    feed_rdata(pick_word());
                end
            end else if (pick < 50) begin
                size = $urandom_range(1, 6);
                if (size == cmd_len(8'(op)))
                    size = size + 1;
                send_frame(size, 1'b0);
            end else if (pick < 58) begin
                body[0] = 8'($urandom_range(4, 255));
                send_frame($urandom_range(1, 6), 1'b0);
            end else if (pick < 63) begin
                send_frame(0, 1'b0);
            end else if (pick < 71) begin
                send_frame(cmd_len(8'(op)), 1'b1);
            end else if (pick < 77) begin
                b = 8'($urandom);
                feed_byte((b == RX_HEADER) ? 8'h00 : b);
            end else if (pick < 83 && lim_len != 8'hFF) begin
                feed_byte(RX_HEADER);
                feed_byte(8'($urandom_range(int'(lim_len) + 1, 255)));
            end else if (pick < 90 && tmo_ticks <= 16'd8) begin
                // partial frame, then just enough ticks to drop it
                feed_byte(RX_HEADER);
                if (lim_len != 8'h00 && $urandom_range(0, 1) == 1)
                    feed_byte(8'($urandom_range(1, int'(lim_len))));
                repeat (int'(tmo_ticks) + 1)
                    feed_tick();
            end else begin
                feed_noise();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer items in bursts with random gaps, hold until taken
    // ------------------------------------------------------------------
    bridge_in_t cur_item;
    bit         feeding = 1'b0;   // an item is on the input port
    bit         in_took = 1'b0;   // set by the monitor on acceptance
    int         burst_left = 1;
    int         gap_left = 0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (in_took) begin
                in_took = 1'b0;
                feeding = 1'b0;
            end
            if (!feeding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (feed_q.size() > 0) begin
                    cur_item = feed_q.pop_front();
                    feeding = 1'b1;
                    command <= cur_item.code;
                    rx_byte <= cur_item.data_byte;
                    read_value <= cur_item.rd_value;
                    if (burst_left <= 1) begin
                        // start a new burst; some bursts follow with no gap
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
            in_valid <= feeding;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of free, light and heavy stretches,
    // plus one long hold-off that backs the block up into its input
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;
    int squeeze_left = 0;
    bit squeezed = 1'b0;

    always @(negedge clk) begin
        if (squeeze_left > 0) begin
            squeeze_left--;
            out_stall <= 1'b1;
        end else if (!squeezed && items_in >= 40) begin
            squeezed = 1'b1;
            squeeze_left = SQUEEZE_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(8, 60);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ------------------------------------------------------------------
    bridge_out_t want_res;

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_item(scfb_cmd_t'(command), rx_byte, read_value);
                in_took = 1'b1;
                items_in++;
            end
            if (out_valid && !out_stall) begin
                if (owed_q.size() == 0) begin
                    $error("result with none expected: kind %0d tx_byte 0x%0h dev_op %0d",
                           kind, tx_byte, dev_op);
                    mismatches++;
                end else begin
                    want_res = owed_q.pop_front();
                    check_field("kind", 16'(want_res.kind), 16'(kind));
                    check_field("tx_byte", 16'(want_res.tx_byte), 16'(tx_byte));
                    check_field("dev_op", 16'(want_res.dev_op), 16'(dev_op));
                    check_field("dev_reg", 16'(want_res.dev_reg), 16'(dev_reg));
                    check_field("dev_value", want_res.dev_value, dev_value);
                    check_field("last", 16'(want_res.last), 16'(last));
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves for too long
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, phases of register settings, final verdict
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MAX_PAYLOAD)
            lim_len = val[7:0];
        else
            tmo_ticks = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until everything is sent and answered, then let the pipe empty
    task automatic drain();
        @(posedge clk);
        while (feed_q.size() != 0 || feeding || owed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset settings
        feed_byte(8'hFF);                       // stray bytes: bad header
        feed_byte(8'h00);
        body[0] = {6'd0, OP_RESET};
        send_frame(1, 1'b0);
        body[0] = {6'd0, OP_READ};
        body[1] = 8'hFF;
        send_frame(2, 1'b0);
        feed_byte(RX_HEADER);                   // dropped: read outstanding
        feed_tick();                            // ignored: read outstanding
        feed_rdata(16'hFFFF);                   // closes the read
        feed_rdata(16'h0000);                   // stray read data
        feed(CMD_UNUSED, 8'hFF, 16'hFFFF);      // unused code
        send_frame(0, 1'b0);                    // empty payload
        body[0] = {6'd0, OP_RESET};
        body[1] = 8'h00;
        send_frame(2, 1'b0);                    // known command, wrong length
        feed_tick();
        drain();

        // Small size limit, short timeout
        write_reg(REG_MAX_PAYLOAD, 16'd4);
        write_reg(REG_IDLE_TIMEOUT, 16'd3);
        random_traffic(25);
        drain();

        // Low extremes: only empty frames fit, timeout after two ticks
        write_reg(REG_MAX_PAYLOAD, 16'd0);
        write_reg(REG_IDLE_TIMEOUT, 16'd1);
        random_traffic(15);
        drain();

        // High extremes: a long frame keeps only its first four payload bytes
        write_reg(REG_MAX_PAYLOAD, 16'd255);
        write_reg(REG_IDLE_TIMEOUT, 16'hFFFF);
        for (int i = 0; i < 12; i++)
            body[i] = 8'($urandom);
        body[0] = {6'd0, OP_WRITE};
        send_frame(12, 1'b0);
        random_traffic(20);
        drain();

        // Random middle settings
        write_reg(REG_MAX_PAYLOAD, 16'($urandom_range(2, 10)));
        write_reg(REG_IDLE_TIMEOUT, 16'($urandom_range(2, 6)));
        random_traffic(15);
        drain();

        if (mismatches == 0 && owed_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
